// ----- src/bdq_pkg.sv -----
package bdq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [2:0] FUNC_PUSH_LEFT  = 3'd0;
    localparam logic [2:0] FUNC_PUSH_RIGHT = 3'd1;
    localparam logic [2:0] FUNC_POP_LEFT   = 3'd2;
    localparam logic [2:0] FUNC_POP_RIGHT  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR      = 3'd4;

    localparam logic [2:0] ST_PUSHED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_POPPED  = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]                func;
        logic signed [VALUE_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]                status;
        logic                      side;
        logic signed [VALUE_W-1:0] result_value;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD        = 3'd0,
        CELL_SHIFT_RIGHT = 3'd1,
        CELL_SHIFT_LEFT  = 3'd2,
        CELL_LOAD_TAIL   = 3'd3,
        CELL_DROP_TAIL   = 3'd4,
        CELL_CLEAR       = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [VALUE_W-1:0] push_value;
    } t_cell_ctl;

endpackage

// ----- src/bdq_cell.sv -----
module bdq_cell
    import bdq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_left_value,
    input  logic                      i_left_valid,
    input  logic signed [VALUE_W-1:0] i_right_value,
    input  logic                      i_right_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_tail_value
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      r_valid;
    logic                      n_valid;
    logic                      w_is_tail;

    assign w_is_tail = r_valid && !i_right_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        case (i_ctl.op)
            CELL_SHIFT_RIGHT: begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
            CELL_SHIFT_LEFT: begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
            CELL_LOAD_TAIL: begin
                if (!r_valid && i_left_valid) begin
                    n_value = i_ctl.push_value;
                    n_valid = 1'b1;
                end
            end
            CELL_DROP_TAIL: begin
                if (w_is_tail) begin
                    n_valid = 1'b0;
                end
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_value = r_value;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_valid      = r_valid;
    assign o_tail_value = w_is_tail ? r_value : '0;

endmodule

// ----- src/bounded_double_ended_queue.sv -----
// Cells shift, load, drop or clear as an accepted item's result is registered.
// Throughput: one item per cycle unless the input is stalled.
// Input stall is raised only while a held result is itself stalled.
// Reset (synchronous, active low): all cells empty, fill count zero, capacity 16,
// no result pending. Stored values are not cleared.
module bounded_double_ended_queue
    import bdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]          r_cap;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_out_item                 r_out;
    t_out_item                 n_out;
    t_cell_ctl                 w_ctl;
    logic                      w_accept;
    logic                      w_room;
    logic                      w_nonempty;
    logic signed [VALUE_W-1:0] w_tail_value;

    logic signed [VALUE_W-1:0] w_value [DEPTH];
    logic                      w_valid [DEPTH];
    logic signed [VALUE_W-1:0] w_tail  [DEPTH];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_room = (CMP_W'(r_count) < CMP_W'(DEPTH)) && (CMP_W'(r_count) < CMP_W'(r_cap));
    assign w_nonempty = (r_count != '0);

    always_comb begin
        w_tail_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail_value = w_tail_value | w_tail[i];
        end
    end

    always_comb begin
        w_ctl.op         = CELL_HOLD;
        w_ctl.push_value = i_in_item.push_value;
        n_count          = r_count;
        n_out_valid      = r_out_valid && i_out_stall;
        n_out            = r_out;
        if (w_accept) begin
            n_out.result_value = '0;
            case (i_in_item.func)
                FUNC_PUSH_LEFT, FUNC_PUSH_RIGHT: begin
                    n_out_valid = 1'b1;
                    n_out.side  = (i_in_item.func == FUNC_PUSH_LEFT) ? SIDE_LEFT : SIDE_RIGHT;
                    if (w_room) begin
                        w_ctl.op = (i_in_item.func == FUNC_PUSH_LEFT) ?
                                   CELL_SHIFT_RIGHT : CELL_LOAD_TAIL;
                        n_count            = r_count + 1'b1;
                        n_out.status       = ST_PUSHED;
                        n_out.result_value = i_in_item.push_value;
                    end else begin
                        n_out.status = ST_FULL;
                    end
                end
                FUNC_POP_LEFT, FUNC_POP_RIGHT: begin
                    n_out_valid = 1'b1;
                    n_out.side  = (i_in_item.func == FUNC_POP_LEFT) ? SIDE_LEFT : SIDE_RIGHT;
                    if (w_nonempty) begin
                        n_count      = r_count - 1'b1;
                        n_out.status = ST_POPPED;
                        if (i_in_item.func == FUNC_POP_LEFT) begin
                            w_ctl.op           = CELL_SHIFT_LEFT;
                            n_out.result_value = w_value[0];
                        end else begin
                            w_ctl.op           = CELL_DROP_TAIL;
                            n_out.result_value = w_tail_value;
                        end
                    end else begin
                        n_out.status = ST_EMPTY;
                    end
                end
                FUNC_CLEAR: begin
                    w_ctl.op     = CELL_CLEAR;
                    n_count      = '0;
                    n_out_valid  = 1'b1;
                    n_out.status = ST_CLEARED;
                    n_out.side   = SIDE_LEFT;
                end
                default: begin
                    n_out = r_out;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_lv;
        logic                      w_lf;
        logic signed [VALUE_W-1:0] w_rv;
        logic                      w_rf;

        if (g == 0) begin : g_left_end
            assign w_lv = i_in_item.push_value;
            assign w_lf = 1'b1;
        end else begin : g_left_mid
            assign w_lv = w_value[g-1];
            assign w_lf = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_right_end
            assign w_rv = '0;
            assign w_rf = 1'b0;
        end else begin : g_right_mid
            assign w_rv = w_value[g+1];
            assign w_rf = w_valid[g+1];
        end

        bdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_value  (w_lv),
            .i_left_valid  (w_lf),
            .i_right_value (w_rv),
            .i_right_valid (w_rf),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_tail_value  (w_tail[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
